FILE: hdl/bmm_pkg.sv
// Shared types, codes and constants of the banked memory mapper.
`timescale 1ns / 1ps
`default_nettype none
package bmm_pkg;

  localparam int SLOT_COUNT_DEF = 8;

  // Request codes
  localparam logic [2:0] REQ_RST_ASSERT  = 3'd0;
  localparam logic [2:0] REQ_RST_RELEASE = 3'd1;
  localparam logic [2:0] REQ_PORT_WR     = 3'd2;
  localparam logic [2:0] REQ_PORT_RD     = 3'd3;
  localparam logic [2:0] REQ_LOOKUP      = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_ALL_RAM    = 2'd0;
  localparam logic [1:0] CFG_PORT_MASK  = 2'd1;
  localparam logic [1:0] CFG_PORT_MATCH = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0]  PORT_MASK_RST  = 8'hFF;
  localparam logic [7:0]  PORT_MATCH_RST = 8'h00;
  localparam logic [7:0]  PORT_NOMATCH   = 8'hFF;
  localparam logic [13:0] BLOCK_SIZE     = 14'd8192;
  localparam logic [16:0] VRAM_FIRST     = 17'h0C000;
  localparam logic [16:0] VRAM_SECOND    = 17'h1C000;
  localparam logic [1:0]  WIN_HALF_RD    = 2'd2;  // read table maps one slot only here

  typedef logic [4:0] wr_slot_t;  // RAM block number
  typedef logic [5:0] rd_slot_t;  // bit 5 = ROM, bits 4..0 = RAM block

  localparam int ROM_BIT = 5;
  localparam rd_slot_t RD_SLOT_ROM = 6'h20;

  typedef struct packed {
    logic       rst_assert;
    logic       rst_release;
    logic       page_wr;
    logic [7:0] page_data;
  } bmm_cmd_t;

  typedef struct packed {
    logic [3:0] bank;
    logic [1:0] window;
    logic       second_vram;
    logic       in_reset;
  } bmm_page_t;

  typedef struct packed {
    logic        found;
    logic        from_rom;
    logic [17:0] ram_address;
    logic [12:0] rom_offset;
    logic [13:0] span;
  } bmm_lookup_t;

endpackage
`default_nettype wire

FILE: hdl/bmm_ifs.sv
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps
`default_nettype none
interface bmm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  port;
  logic [7:0]  data;
  logic [15:0] address;
  logic        is_read;
  logic [16:0] length;

  modport source (output valid, req_type, port, data, address, is_read, length,
                  input ready);
  modport sink (input valid, req_type, port, data, address, is_read, length,
                output ready);
endinterface

interface bmm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  port_data;
  logic        found;
  logic        from_rom;
  logic [17:0] ram_address;
  logic [12:0] rom_offset;
  logic [13:0] span;
  logic        redraw;
  logic [16:0] vram_offset;

  modport source (output valid, port_data, found, from_rom, ram_address, rom_offset,
                  span, redraw, vram_offset, input ready);
  modport sink (input valid, port_data, found, from_rom, ram_address, rom_offset,
                span, redraw, vram_offset, output ready);
endinterface
`default_nettype wire

FILE: hdl/banked_memory_mapper_unit.sv
// Top level of the banked memory mapper: request register, tables, result register.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------------
//  in_ch   | in  | valid/ready   | req_type, port, data, address, is_read, length
//  out_ch  | out | valid/ready   | port_data, found, from_rom, ram_address,
//          |     |               | rom_offset, span, redraw, vram_offset
//  cfg_*   | in  | write enable  | cfg_index, cfg_data (all_ram, port_mask, port_match)
//
// One item per cycle sustained while out_ch is not stalled.
// Item lands in the request register, then one pass of table/lookup logic
// updates the page state and loads the result register in the same edge.
// A stalled output holds the result register; the request register then
// holds too, and in_ch.ready drops once both are full.
// Synchronous reset: ROM in every read slot, identity write table, in reset.
`timescale 1ns / 1ps
`default_nettype none
module banked_memory_mapper_unit
  import bmm_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  bmm_in_if.sink               in_ch,
  bmm_out_if.source            out_ch,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);

  // configuration
  logic       all_ram_r;
  logic [7:0] port_mask_r;
  logic [7:0] port_match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_ram_r    <= 1'b0;
      port_mask_r  <= PORT_MASK_RST;
      port_match_r <= PORT_MATCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALL_RAM:    all_ram_r    <= cfg_data[0];
        CFG_PORT_MASK:  port_mask_r  <= cfg_data;
        CFG_PORT_MATCH: port_match_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // request register
  logic        s1_valid_r;
  logic [2:0]  s1_req_r;
  logic [7:0]  s1_port_r;
  logic [7:0]  s1_data_r;
  logic [15:0] s1_addr_r;
  logic        s1_is_read_r;
  logic [16:0] s1_len_r;

  logic s1_adv;
  logic in_acc;

  assign s1_adv      = s1_valid_r && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r     <= in_ch.req_type;
      s1_port_r    <= in_ch.port;
      s1_data_r    <= in_ch.data;
      s1_addr_r    <= in_ch.address;
      s1_is_read_r <= in_ch.is_read;
      s1_len_r     <= in_ch.length;
    end
  end

  // decode and tables
  logic        match;
  bmm_cmd_t    cmd;
  bmm_page_t   page;
  bmm_page_t   page_nxt;
  wr_slot_t    wr_slot;
  rd_slot_t    rd_slot;
  bmm_lookup_t lk;

  assign match = (s1_port_r & port_mask_r) == port_match_r;

  always_comb begin
    cmd             = '0;
    cmd.page_data   = s1_data_r;
    cmd.rst_assert  = s1_adv && (s1_req_r == REQ_RST_ASSERT);
    cmd.rst_release = s1_adv && (s1_req_r == REQ_RST_RELEASE);
    cmd.page_wr     = s1_adv && (s1_req_r == REQ_PORT_WR) && match;
  end

  bmm_slot_tables #(.SLOT_COUNT(SLOT_COUNT)) u_tables (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .idx      (s1_addr_r[13 +: SLOT_W]),
    .wr_slot  (wr_slot),
    .rd_slot  (rd_slot),
    .page     (page),
    .page_nxt (page_nxt)
  );

  bmm_lookup u_lookup (
    .address  (s1_addr_r),
    .length   (s1_len_r),
    .is_read  (s1_is_read_r),
    .all_ram  (all_ram_r),
    .in_reset (page.in_reset),
    .wr_slot  (wr_slot),
    .rd_slot  (rd_slot),
    .res      (lk)
  );

  // result register
  logic        out_valid_r;
  logic [7:0]  port_data_r;
  bmm_lookup_t lk_r;
  logic        redraw_r;
  logic [16:0] vram_r;

  logic [7:0]  port_data_nxt;
  bmm_lookup_t lk_nxt;
  logic        redraw_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    port_data_nxt = 8'd0;
    lk_nxt        = '0;
    redraw_nxt    = 1'b0;
    case (s1_req_r)
      REQ_PORT_RD: begin
        port_data_nxt = match ? {1'b0, page.second_vram, page.window, page.bank}
                              : PORT_NOMATCH;
      end
      REQ_PORT_WR: begin
        redraw_nxt = match && (s1_data_r[6] != page.second_vram);
      end
      REQ_LOOKUP: begin
        lk_nxt = lk;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      port_data_r <= port_data_nxt;
      lk_r        <= lk_nxt;
      redraw_r    <= redraw_nxt;
      vram_r      <= page_nxt.second_vram ? VRAM_SECOND : VRAM_FIRST;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.port_data   = port_data_r;
  assign out_ch.found       = lk_r.found;
  assign out_ch.from_rom    = lk_r.from_rom;
  assign out_ch.ram_address = lk_r.ram_address;
  assign out_ch.rom_offset  = lk_r.rom_offset;
  assign out_ch.span        = lk_r.span;
  assign out_ch.redraw      = redraw_r;
  assign out_ch.vram_offset = vram_r;

  // checks
  a_found_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && lk_r.found |-> lk_r.span != 14'd0)
    else $error("found lookup with zero span");

  a_rom_no_ram: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && lk_r.from_rom |-> lk_r.found && lk_r.ram_address == 18'd0)
    else $error("ROM result carries a RAM address");

  a_assert_reset: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rst_assert |=> page.in_reset && page.bank == 4'd0 && page.window == 2'd0)
    else $error("reset assert did not clear the page state");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item left no result");

  a_redraw_vram: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && cmd.page_wr && (s1_data_r[6] != page.second_vram)
      |=> page.second_vram == $past(s1_data_r[6]))
    else $error("page write did not switch the VRAM select");

endmodule
`default_nettype wire

FILE: hdl/bmm_slot_tables.sv
// Page register and the write and read slot tables.
`timescale 1ns / 1ps
`default_nettype none
module bmm_slot_tables
  import bmm_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int SLOT_W = $clog2(SLOT_COUNT)
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire bmm_cmd_t    cmd,
  input  wire [SLOT_W-1:0] idx,
  output wr_slot_t         wr_slot,
  output rd_slot_t         rd_slot,
  output bmm_page_t        page,
  output bmm_page_t        page_nxt
);

  wr_slot_t  wr_slots_r  [SLOT_COUNT];
  wr_slot_t  wr_slots_nxt[SLOT_COUNT];
  rd_slot_t  rd_slots_r  [SLOT_COUNT];
  rd_slot_t  rd_slots_nxt[SLOT_COUNT];
  bmm_page_t page_r;
  bmm_page_t pg_nxt;

  always_comb begin
    pg_nxt = page_r;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      wr_slots_nxt[i] = wr_slots_r[i];
      rd_slots_nxt[i] = rd_slots_r[i];
    end
    if (cmd.rst_assert) begin
      pg_nxt = '{bank: 4'd0, window: 2'd0, second_vram: 1'b0, in_reset: 1'b1};
      for (int i = 0; i < SLOT_COUNT; i++) begin
        wr_slots_nxt[i] = wr_slot_t'(i);
        rd_slots_nxt[i] = RD_SLOT_ROM;
      end
    end else if (cmd.rst_release) begin
      if (page_r.in_reset) begin
        pg_nxt = '{bank: 4'd0, window: 2'd0, second_vram: 1'b0, in_reset: 1'b0};
        for (int i = 0; i < SLOT_COUNT - 1; i++) begin
          rd_slots_nxt[i] = rd_slot_t'(i);
        end
      end
    end else if (cmd.page_wr) begin
      pg_nxt.bank        = cmd.page_data[3:0];
      pg_nxt.window      = cmd.page_data[5:4];
      pg_nxt.second_vram = cmd.page_data[6];
      for (int i = 0; i < SLOT_COUNT; i++) begin
        // new pair wins over the restored identity pair
        if ((i >> 1) == int'(pg_nxt.window)) begin
          wr_slots_nxt[i] = {pg_nxt.bank, (i & 1) != 0};
          if (!(pg_nxt.window == WIN_HALF_RD && (i & 1) != 0))
            rd_slots_nxt[i] = {1'b0, pg_nxt.bank, (i & 1) != 0};
        end else if ((i >> 1) == int'(page_r.window)) begin
          wr_slots_nxt[i] = wr_slot_t'(i);
          if (!(page_r.window == WIN_HALF_RD && (i & 1) != 0))
            rd_slots_nxt[i] = rd_slot_t'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= '{bank: 4'd0, window: 2'd0, second_vram: 1'b0, in_reset: 1'b1};
      for (int i = 0; i < SLOT_COUNT; i++) begin
        wr_slots_r[i] <= wr_slot_t'(i);
        rd_slots_r[i] <= RD_SLOT_ROM;
      end
    end else begin
      page_r <= pg_nxt;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        wr_slots_r[i] <= wr_slots_nxt[i];
        rd_slots_r[i] <= rd_slots_nxt[i];
      end
    end
  end

  assign wr_slot  = wr_slots_r[idx];
  assign rd_slot  = rd_slots_r[idx];
  assign page     = page_r;
  assign page_nxt = pg_nxt;

endmodule
`default_nettype wire

FILE: hdl/bmm_lookup.sv
// Address translation and span computation for one lookup.
`timescale 1ns / 1ps
`default_nettype none
module bmm_lookup
  import bmm_pkg::*;
(
  input  wire [15:0]    address,
  input  wire [16:0]    length,
  input  wire           is_read,
  input  wire           all_ram,
  input  wire           in_reset,
  input  wire wr_slot_t wr_slot,
  input  wire rd_slot_t rd_slot,
  output bmm_lookup_t   res
);

  logic        len_ok;
  logic [12:0] off;
  logic [13:0] rest;
  rd_slot_t    slot;

  always_comb begin
    len_ok = (length != 17'd0) && (!length[16] || length[15:0] == 16'd0);
    off    = address[12:0];
    rest   = BLOCK_SIZE - {1'b0, off};
    slot   = (is_read && (!all_ram || in_reset)) ? rd_slot : {1'b0, wr_slot};
    res    = '0;
    if (len_ok) begin
      res.found = 1'b1;
      if (slot[ROM_BIT]) begin
        res.from_rom   = 1'b1;
        res.rom_offset = off;
      end else begin
        res.ram_address = {slot[4:0], off};
      end
      res.span = (length < {3'b000, rest}) ? length[13:0] : rest;
    end
  end

endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for banked_memory_mapper_unit: directed and random request items.
`timescale 1ns / 1ps
module tb;
  import bmm_pkg::*;

  // Cycles with no handshake on either channel before the run is declared hung.
  // Random stalls are short, so reaching this limit without a handshake means a hang.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 100;
  // Settle time at the end of the run, after the last drain.
  localparam int TAIL_CYCLES = 8;
  localparam logic [2:0] REQ_LAST = 3'd7;           // highest (unused) request code
  localparam logic [16:0] LEN_LIMIT = 17'h10000;    // longest valid lookup length

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  port;
    logic [7:0]  data;
    logic [15:0] address;
    logic        is_read;
    logic [16:0] length;
  } map_req_t;

  typedef struct packed {
    logic [7:0]  port_data;
    logic        found;
    logic        from_rom;
    logic [17:0] ram_address;
    logic [12:0] rom_offset;
    logic [13:0] span;
    logic        redraw;
    logic [16:0] vram_offset;
  } map_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bmm_in_if  in_if ();
  bmm_out_if out_if ();

  banked_memory_mapper_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Mapper model: config copy, page fields and both slot tables
  // ---------------------------------------------------------------------------
  logic       all_ram_q;
  logic [7:0] mask_q;
  logic [7:0] match_q;
  logic [3:0] bank_q;
  logic [1:0] win_q;
  logic       vram_q;
  logic       in_rst_q;
  wr_slot_t   wr_tbl [SLOT_COUNT_DEF];
  rd_slot_t   rd_tbl [SLOT_COUNT_DEF];

  map_req_t    pending_reqs[$];      // items not yet offered to the block
  map_result_t expected_results[$];  // predictions waiting for their result item

  int  send_idle_pct;
  int  recv_stall_pct;
  int  n_sent;        // items taken off pending_reqs by the driver
  int  n_results;     // result items seen
  int  n_failures;
  int  idle_cycles;
  logic in_taken;     // input item accepted at the last rising edge

  function automatic void clear_page();
    bank_q = '0;
    win_q  = '0;
    vram_q = 1'b0;
  endfunction

  // Reset assert: ROM in all read slots, identity write table.
  function automatic void enter_reset();
    in_rst_q = 1'b1;
    clear_page();
    for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
      wr_tbl[i] = wr_slot_t'(i);
      rd_tbl[i] = RD_SLOT_ROM;
    end
  endfunction

  // Bank pair into a window; the read table only takes the first slot of the half window.
  function automatic void map_pair(logic [1:0] win, logic [3:0] bank);
    wr_tbl[{win, 1'b0}] = {bank, 1'b0};
    wr_tbl[{win, 1'b1}] = {bank, 1'b1};
    rd_tbl[{win, 1'b0}] = {1'b0, bank, 1'b0};
    if (win != WIN_HALF_RD) begin
      rd_tbl[{win, 1'b1}] = {1'b0, bank, 1'b1};
    end
  endfunction

  function automatic map_result_t translate_item(map_req_t r);
    map_result_t res;
    logic        hit;
    logic        nv;
    logic [12:0] off;
    logic [13:0] rest;
    rd_slot_t    slot;
    res = '0;
    hit = ((r.port & mask_q) == match_q);
    case (r.req_type)
      REQ_RST_ASSERT: enter_reset();
      REQ_RST_RELEASE: begin
        // ignored outside reset; slot 7 of the read table keeps its content
        if (in_rst_q) begin
          in_rst_q = 1'b0;
          clear_page();
          for (int i = 0; i < SLOT_COUNT_DEF - 1; i++) rd_tbl[i] = rd_slot_t'(i);
        end
      end
      REQ_PORT_WR: begin
        if (hit) begin
          nv = r.data[6];
          map_pair(win_q, {2'b00, win_q});  // old window back to identity
          res.redraw = (nv != vram_q);
          bank_q = r.data[3:0];
          win_q  = r.data[5:4];
          vram_q = nv;
          map_pair(win_q, bank_q);
        end
      end
      REQ_PORT_RD: res.port_data = hit ? {1'b0, vram_q, win_q, bank_q} : PORT_NOMATCH;
      REQ_LOOKUP: begin
        if (r.length != '0 && r.length <= LEN_LIMIT) begin
          off  = r.address[12:0];
          rest = BLOCK_SIZE - {1'b0, off};
          if (r.is_read && (!all_ram_q || in_rst_q)) begin
            slot = rd_tbl[r.address[15:13]];
          end else begin
            slot = {1'b0, wr_tbl[r.address[15:13]]};
          end
          res.found = 1'b1;
          if (slot[ROM_BIT]) begin
            res.from_rom   = 1'b1;
            res.rom_offset = off;
          end else begin
            res.ram_address = {slot[4:0], off};
          end
          res.span = (r.length < {3'b000, rest}) ? r.length[13:0] : rest;
        end
      end
      default: ;  // spare codes change nothing
    endcase
    res.vram_offset = vram_q ? VRAM_SECOND : VRAM_FIRST;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents items at the falling edge, holds them until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    map_req_t nxt;
    logic     nxt_valid;
    if (rst_n) begin
      nxt_valid = in_if.valid && !in_taken;
      if (!nxt_valid && pending_reqs.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        n_sent++;
        nxt_valid = 1'b1;
        in_if.req_type <= nxt.req_type;
        in_if.port     <= nxt.port;
        in_if.data     <= nxt.data;
        in_if.address  <= nxt.address;
        in_if.is_read  <= nxt.is_read;
        in_if.length   <= nxt.length;
      end
      in_if.valid  <= nxt_valid;
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input accept, checks on output accept, runs the watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    map_req_t    req;
    map_result_t got;
    map_result_t want;
    logic        out_taken;
    in_taken  = rst_n && in_if.valid && in_if.ready;
    out_taken = rst_n && out_if.valid && out_if.ready;
    if (in_taken) begin
      req = '{in_if.req_type, in_if.port, in_if.data, in_if.address,
              in_if.is_read, in_if.length};
      expected_results.push_back(translate_item(req));
    end
    if (out_taken) begin
      n_results++;
      got = '{out_if.port_data, out_if.found, out_if.from_rom, out_if.ram_address,
              out_if.rom_offset, out_if.span, out_if.redraw, out_if.vram_offset};
      if (expected_results.size() == 0) begin
        n_failures++;
        if (n_failures <= MAX_REPORTS)
          $display("%0t: result item with nothing expected", $realtime);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          n_failures++;
          if (n_failures <= MAX_REPORTS) begin
            $display("%0t: mismatch on result %0d", $realtime, n_results);
            $display("  expected pd=%h found=%b rom=%b ram=%h roff=%h span=%0d rd=%b vram=%h",
                     want.port_data, want.found, want.from_rom, want.ram_address,
                     want.rom_offset, want.span, want.redraw, want.vram_offset);
            $display("  actual   pd=%h found=%b rom=%b ram=%h roff=%h span=%0d rd=%b vram=%h",
                     got.port_data, got.found, got.from_rom, got.ram_address,
                     got.rom_offset, got.span, got.redraw, got.vram_offset);
          end
        end
      end
    end
    if (rst_n) begin
      idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_req(logic [2:0] kind, logic [7:0] port, logic [7:0] data,
                           logic [15:0] addr, logic rd, logic [16:0] len);
    pending_reqs.push_back('{kind, port, data, addr, rd, len});
  endtask

  // Registers only change with nothing in flight, so the model copy follows at once.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ALL_RAM:    all_ram_q = val[0];
      CFG_PORT_MASK:  mask_q    = val;
      CFG_PORT_MATCH: match_q   = val;
      default: ;
    endcase
  endtask

  // Sender holds off until every queued item has come back as a result.
  task automatic wait_drain();
    while (pending_reqs.size() != 0 || n_results < n_sent) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          pick;
    int          lsel;
    logic [7:0]  r_mask;
    logic [7:0]  r_match;
    logic        r_all_ram;
    map_req_t    item;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.req_type = '0;
    in_if.port     = '0;
    in_if.data     = '0;
    in_if.address  = '0;
    in_if.is_read  = 1'b0;
    in_if.length   = '0;
    out_if.ready   = 1'b0;
    in_taken       = 1'b0;
    n_sent         = 0;
    n_results      = 0;
    n_failures     = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    all_ram_q      = 1'b0;
    mask_q         = PORT_MASK_RST;
    match_q        = PORT_MATCH_RST;
    enter_reset();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values (mask FF, match 00), no idling.
    queue_req(REQ_PORT_RD, 8'h00, 8'h00, 16'h0000, 1'b0, 17'd0);       // matched read
    queue_req(REQ_PORT_RD, 8'hFF, 8'hFF, 16'h0000, 1'b0, 17'd0);       // unmatched port
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'h0000, 1'b1, 17'd1);       // ROM in reset
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'hFFFF, 1'b0, LEN_LIMIT);   // last byte
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'h2000, 1'b1, 17'd0);       // zero length
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'h2000, 1'b1, LEN_LIMIT + 17'd1); // too long
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'h2000, 1'b0, 17'h1FFFF);
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'h1234, 1'b1, LEN_LIMIT);
    queue_req(REQ_PORT_WR, 8'h00, 8'hFF, 16'h0000, 1'b0, 17'd0);       // page write in reset
    queue_req(REQ_PORT_RD, 8'h00, 8'h00, 16'h0000, 1'b0, 17'd0);
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'hE000, 1'b1, 17'd16);
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'hC000, 1'b0, 17'd8192);
    queue_req(REQ_RST_RELEASE, 8'h00, 8'h00, 16'h0000, 1'b0, 17'd0);
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'hE000, 1'b1, 17'd8192);    // slot 7 kept
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'hA100, 1'b1, 17'd9000);
    queue_req(REQ_RST_RELEASE, 8'h00, 8'h00, 16'h0000, 1'b0, 17'd0);   // ignored
    queue_req(REQ_PORT_WR, 8'h00, 8'h25, 16'h0000, 1'b0, 17'd0);       // half window
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'h4000, 1'b1, 17'd1);
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'h5FFF, 1'b1, 17'd100);     // read slot untouched
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'h5FFF, 1'b0, 17'd100);
    queue_req(REQ_PORT_WR, 8'h00, 8'h40, 16'h0000, 1'b0, 17'd0);       // vram flips
    queue_req(REQ_PORT_WR, 8'h00, 8'h40, 16'h0000, 1'b0, 17'd0);       // no flip
    queue_req(REQ_PORT_WR, 8'h01, 8'h3F, 16'h0000, 1'b0, 17'd0);       // wrong port
    for (int c = REQ_LOOKUP + 1; c <= REQ_LAST; c++)
      queue_req(c[2:0], 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 17'h1FFFF);
    queue_req(REQ_RST_ASSERT, 8'h00, 8'h00, 16'h0000, 1'b0, 17'd0);
    queue_req(REQ_LOOKUP,  8'h00, 8'h00, 16'h8000, 1'b1, 17'd2);
    wait_drain();

    // Random phases: a register setting per phase, idling rotates through four modes.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin r_all_ram = 1'b0; r_mask = 8'hFF; r_match = 8'h00; end
        1:       begin r_all_ram = 1'b1; r_mask = 8'hF0; r_match = 8'h80; end
        2:       begin r_all_ram = 1'b1; r_mask = 8'h00; r_match = 8'h00; end
        3:       begin r_all_ram = 1'b0; r_mask = 8'hFF; r_match = 8'hFF; end
        4:       begin r_all_ram = 1'b1; r_mask = 8'h0F; r_match = 8'h0A; end
        default: begin r_all_ram = 1'b0; r_mask = 8'h00; r_match = 8'h01; end  // never hits
      endcase
      write_reg(CFG_ALL_RAM, {7'd0, r_all_ram});
      write_reg(CFG_PORT_MASK, r_mask);
      write_reg(CFG_PORT_MATCH, r_match);
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mostly lookups and page writes; resets now and then to reopen the tables
        pick = $urandom_range(99);
        if (pick < 50)      item.req_type = REQ_LOOKUP;
        else if (pick < 70) item.req_type = REQ_PORT_WR;
        else if (pick < 80) item.req_type = REQ_PORT_RD;
        else if (pick < 88) item.req_type = REQ_RST_RELEASE;
        else if (pick < 94) item.req_type = REQ_RST_ASSERT;
        else                item.req_type = 3'($urandom_range(REQ_LAST, REQ_LOOKUP + 1));
        item.port = 8'($urandom);
        if ($urandom_range(3) != 0) item.port = (item.port & ~mask_q) | match_q;
        item.data    = 8'($urandom);
        item.address = 16'($urandom);
        item.is_read = 1'($urandom_range(1));
        lsel = $urandom_range(19);
        if (lsel < 14)       item.length = 17'($urandom_range(8192, 1));
        else if (lsel == 14) item.length = 17'($urandom_range(LEN_LIMIT, 8193));
        else if (lsel == 15) item.length = '0;
        else if (lsel == 16) item.length = LEN_LIMIT;
        else if (lsel == 17) item.length = 17'($urandom_range(17'h1FFFF, LEN_LIMIT + 1));
        else                 item.length = 17'($urandom);
        pending_reqs.push_back(item);
      end
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) n_failures++;
    if (n_failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
